// File: hdl/salcd_pkg.sv
package salcd_pkg;

    localparam int KEY_W    = 32;
    localparam int BYTES_W  = 32;
    localparam int STATUS_W = 3;
    localparam int EVCNT_W  = 7;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status STATUS_HIT      = 3'd0;
    localparam t_status STATUS_MISS     = 3'd1;
    localparam t_status STATUS_INSERTED = 3'd2;
    localparam t_status STATUS_PRESENT  = 3'd3;
    localparam t_status STATUS_TOO_BIG  = 3'd4;
    localparam t_status STATUS_DISABLED = 3'd5;

    localparam logic [EVCNT_W-1:0] EVCNT_MAX = '1;

endpackage

// File: hdl/salcd_mem.sv
module salcd_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 70
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/size_aware_lru_cache_directory.sv
// Byte-budgeted LRU cache directory.
// Input channel (i_in_valid / o_in_stall) carries one request: i_op selects
// lookup (0) or insert (1), with i_key and i_obj_size. Output channel
// (o_out_valid / i_out_stall) returns one result per request: o_status,
// o_evicted_count and o_free_bytes_now. The configuration channel
// (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the byte budget; a write
// empties the directory and sets the free byte count to the new budget.
// Entries live in one synchronous RAM that is swept one slot per cycle.
// A lookup takes one search sweep, plus a recency update sweep on a hit.
// An insert takes one search sweep and, when it goes in, one sweep per
// evicted entry and one aging/placement sweep. With the cache disabled,
// a request skips every sweep and goes straight to the output stage.
// One request is handled at a time; the next transfer is taken once the
// result sits in the output register, even while it waits.
// Reset clears the valid bits, the budget (disabling the cache) and the
// output valid flag. When the receiver stalls, the finished result is held
// stable in the output register and further results wait behind it.
module size_aware_lru_cache_directory #(
    parameter int SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [salcd_pkg::KEY_W-1:0]     i_key,
    input  logic [salcd_pkg::BYTES_W-1:0]   i_obj_size,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [salcd_pkg::STATUS_W-1:0]  o_status,
    output logic [salcd_pkg::EVCNT_W-1:0]   o_evicted_count,
    output logic [salcd_pkg::BYTES_W-1:0]   o_free_bytes_now,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [salcd_pkg::BYTES_W-1:0]   i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int EW = salcd_pkg::KEY_W + salcd_pkg::BYTES_W + IW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PASS  = 3'd1;
    localparam logic [2:0] ST_DEC   = 3'd2;
    localparam logic [2:0] ST_EVCHK = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] K_SCAN  = 2'd0;
    localparam logic [1:0] K_TOUCH = 2'd1;
    localparam logic [1:0] K_EVICT = 2'd2;
    localparam logic [1:0] K_AGE   = 2'd3;

    logic [2:0]                          r_state;
    logic [1:0]                          r_kind;
    logic [salcd_pkg::BYTES_W-1:0]       r_cap;
    logic [salcd_pkg::BYTES_W-1:0]       r_free;
    logic [UW-1:0]                       r_used;
    logic [SLOTS-1:0]                    r_valid;
    logic                                r_op;
    logic [salcd_pkg::KEY_W-1:0]         r_key;
    logic [salcd_pkg::BYTES_W-1:0]       r_size;
    logic                                r_iss;
    logic [IW-1:0]                       r_idx;
    logic                                r_pv;
    logic [IW-1:0]                       r_pidx;
    logic                                r_hit;
    logic [IW-1:0]                       r_hidx;
    logic [IW-1:0]                       r_hrec;
    logic [IW-1:0]                       r_tgt;
    logic                                r_placed;
    logic [salcd_pkg::EVCNT_W-1:0]       r_evc;
    salcd_pkg::t_status                  r_res;
    logic                                r_ovld;
    salcd_pkg::t_status                  r_ostat;
    logic [salcd_pkg::EVCNT_W-1:0]       r_oevc;
    logic [salcd_pkg::BYTES_W-1:0]       r_ofree;

    logic [EW-1:0]                       rdata;
    logic [salcd_pkg::KEY_W-1:0]         rd_key;
    logic [salcd_pkg::BYTES_W-1:0]       rd_bytes;
    logic [IW-1:0]                       rd_rec;
    logic                                slot_v;
    logic                                we;
    logic [EW-1:0]                       wdata;
    logic                                in_acc;
    logic                                cfg_acc;
    logic                                pass_end;
    logic                                out_free;
    logic                                need_evict;

    assign rd_key   = rdata[EW-1 -: salcd_pkg::KEY_W];
    assign rd_bytes = rdata[IW +: salcd_pkg::BYTES_W];
    assign rd_rec   = rdata[IW-1:0];
    assign slot_v   = r_valid[r_pidx];

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign pass_end    = r_pv && (r_pidx == IW'(SLOTS - 1));
    assign out_free    = !r_ovld || !i_out_stall;
    assign need_evict  = (r_used != '0)
                         && ((r_free < r_size) || (r_used >= UW'(SLOTS)));

    // Write-back of the slot that was read in the previous cycle.
    always_comb begin
        we    = 1'b0;
        wdata = rdata;
        if (r_state == ST_PASS && r_pv) begin
            case (r_kind)
                K_TOUCH: begin
                    if (slot_v && r_pidx == r_hidx) begin
                        we    = 1'b1;
                        wdata = {rd_key, rd_bytes, {IW{1'b0}}};
                    end else if (slot_v && rd_rec < r_hrec) begin
                        we    = 1'b1;
                        wdata = {rd_key, rd_bytes, rd_rec + 1'b1};
                    end
                end
                K_AGE: begin
                    if (slot_v) begin
                        we    = 1'b1;
                        wdata = {rd_key, rd_bytes, rd_rec + 1'b1};
                    end else if (!r_placed) begin
                        we    = 1'b1;
                        wdata = {r_key, r_size, {IW{1'b0}}};
                    end
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    salcd_mem #(
        .DEPTH(SLOTS),
        .WIDTH(EW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_pidx),
        .i_wdata(wdata),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= '0;
            r_free  <= '0;
            r_used  <= '0;
            r_valid <= '0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            // The output register fills from ST_OUT and empties on a transfer.
            if (r_state == ST_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            // Read issue and read-data alignment of a sweep.
            r_pv   <= r_iss;
            r_pidx <= r_idx;
            if (r_iss) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == IW'(SLOTS - 1)) begin
                    r_iss <= 1'b0;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        r_cap   <= i_cfg_data;
                        r_free  <= i_cfg_data;
                        r_used  <= '0;
                        r_valid <= '0;
                    end else if (in_acc) begin
                        r_op     <= i_op;
                        r_key    <= i_key;
                        r_size   <= i_obj_size;
                        r_hit    <= 1'b0;
                        r_evc    <= '0;
                        r_placed <= 1'b0;
                        if (r_cap == '0) begin
                            r_res   <= salcd_pkg::STATUS_DISABLED;
                            r_state <= ST_OUT;
                        end else begin
                            r_kind  <= K_SCAN;
                            r_iss   <= 1'b1;
                            r_idx   <= '0;
                            r_state <= ST_PASS;
                        end
                    end
                end
                ST_PASS: begin
                    if (r_pv && slot_v) begin
                        case (r_kind)
                            K_SCAN: begin
                                if (rd_key == r_key) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pidx;
                                    r_hrec <= rd_rec;
                                end
                            end
                            K_EVICT: begin
                                if (rd_rec == r_tgt) begin
                                    r_valid[r_pidx] <= 1'b0;
                                    r_free <= r_free + rd_bytes;
                                    r_used <= r_used - 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_pv && !slot_v && r_kind == K_AGE && !r_placed) begin
                        r_valid[r_pidx] <= 1'b1;
                        r_placed <= 1'b1;
                        r_used   <= r_used + 1'b1;
                        r_free   <= r_free - r_size;
                    end
                    if (pass_end) begin
                        case (r_kind)
                            K_SCAN:  r_state <= ST_DEC;
                            K_EVICT: r_state <= ST_EVCHK;
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_DEC: begin
                    if (!r_op) begin
                        if (r_hit) begin
                            r_res   <= salcd_pkg::STATUS_HIT;
                            r_kind  <= K_TOUCH;
                            r_iss   <= 1'b1;
                            r_idx   <= '0;
                            r_state <= ST_PASS;
                        end else begin
                            r_res   <= salcd_pkg::STATUS_MISS;
                            r_state <= ST_OUT;
                        end
                    end else if (r_hit) begin
                        r_res   <= salcd_pkg::STATUS_PRESENT;
                        r_state <= ST_OUT;
                    end else if ({r_size, 1'b0} > {1'b0, r_cap}) begin
                        r_res   <= salcd_pkg::STATUS_TOO_BIG;
                        r_state <= ST_OUT;
                    end else begin
                        r_res   <= salcd_pkg::STATUS_INSERTED;
                        r_state <= ST_EVCHK;
                    end
                end
                ST_EVCHK: begin
                    r_iss   <= 1'b1;
                    r_idx   <= '0;
                    r_state <= ST_PASS;
                    if (need_evict) begin
                        r_kind <= K_EVICT;
                        r_tgt  <= IW'(r_used - 1'b1);
                        if (r_evc != salcd_pkg::EVCNT_MAX) begin
                            r_evc <= r_evc + 1'b1;
                        end
                    end else begin
                        r_kind <= K_AGE;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ostat <= r_res;
                        r_oevc  <= r_evc;
                        r_ofree <= r_free;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_status         = r_ostat;
    assign o_evicted_count  = r_oevc;
    assign o_free_bytes_now = r_ofree;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(SLOTS))
        else $error("slot count exceeds table size");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_used == '0) && (r_valid == '0))
        else $error("configuration write did not empty directory");

    a_evict_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != salcd_pkg::STATUS_INSERTED) |->
            (o_evicted_count == '0))
        else $error("eviction reported on a non-insert result");

    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_cap == '0) |->
            (r_res == salcd_pkg::STATUS_DISABLED))
        else $error("disabled cache returned a non-disabled status");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS       = 64;
    localparam int ITEMS       = 1550;
    localparam int IDLE_LIMIT  = 60000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        salcd_pkg::t_status                     status;
        logic [salcd_pkg::EVCNT_W-1:0]          evicted;
        logic [salcd_pkg::BYTES_W-1:0]          free_now;
    } t_result;

    // One row of the directed stimulus. A row either writes the byte budget
    // or sends one request; typed rows carry the result that is expected.
    typedef struct {
        bit                             is_cfg;
        logic                           op;
        logic [salcd_pkg::KEY_W-1:0]    key;
        logic [salcd_pkg::BYTES_W-1:0]  size;
        bit                             typed;
        t_result                        res;
    } t_row;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic                                   i_op;
    logic [salcd_pkg::KEY_W-1:0]            i_key;
    logic [salcd_pkg::BYTES_W-1:0]          i_obj_size;
    logic                                   o_out_valid;
    logic                                   i_out_stall;
    logic [salcd_pkg::STATUS_W-1:0]         o_status;
    logic [salcd_pkg::EVCNT_W-1:0]          o_evicted_count;
    logic [salcd_pkg::BYTES_W-1:0]          o_free_bytes_now;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [salcd_pkg::BYTES_W-1:0]          i_cfg_data;

    size_aware_lru_cache_directory #(.SLOTS(SLOTS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_obj_size       (i_obj_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_evicted_count  (o_evicted_count),
        .o_free_bytes_now (o_free_bytes_now),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // Shadow copy of the directory, kept in step with every accepted request and budget write.
    bit                             dir_valid [SLOTS];
    logic [salcd_pkg::KEY_W-1:0]    dir_key   [SLOTS];
    logic [salcd_pkg::BYTES_W-1:0]  dir_bytes [SLOTS];
    int                             dir_rank  [SLOTS];
    logic [salcd_pkg::BYTES_W-1:0]  budget;
    logic [salcd_pkg::BYTES_W-1:0]  free_bytes;
    int                             used_slots;

    t_result pending_results[$];
    bit      failed;
    int      idle_cycles;
    int      burst_left;
    bit      hold_go;
    bit      hold_done;
    int      hold_left;
    int      stall_mode;
    int      cycle_cnt;
    int      sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A budget write empties the directory and restores every free byte.
    function automatic void apply_budget(input logic [salcd_pkg::BYTES_W-1:0] value);
        budget     = value;
        free_bytes = value;
        used_slots = 0;
        for (int i = 0; i < SLOTS; i++) dir_valid[i] = 1'b0;
    endfunction

    function automatic int find_slot(input logic [salcd_pkg::KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (dir_valid[i] && dir_key[i] == k) return i;
        return -1;
    endfunction

    function automatic t_result predict_response(input logic op,
                                                 input logic [salcd_pkg::KEY_W-1:0] k,
                                                 input logic [salcd_pkg::BYTES_W-1:0] sz);
        t_result r;
        int      s;
        int      evicted;
        evicted = 0;
        if (budget == 0) begin
            r.status = salcd_pkg::STATUS_DISABLED;
        end else if (op == 1'b0) begin
            s = find_slot(k);
            if (s >= 0) begin
                // A hit moves the entry to the front; newer entries age by one.
                for (int i = 0; i < SLOTS; i++)
                    if (dir_valid[i] && dir_rank[i] < dir_rank[s]) dir_rank[i]++;
                dir_rank[s] = 0;
                r.status = salcd_pkg::STATUS_HIT;
            end else begin
                r.status = salcd_pkg::STATUS_MISS;
            end
        end else if (find_slot(k) >= 0) begin
            r.status = salcd_pkg::STATUS_PRESENT;
        end else if ({1'b0, sz, 1'b0} > {2'b0, budget}) begin
            r.status = salcd_pkg::STATUS_TOO_BIG;
        end else begin
            // Evict from the back until the object fits and a slot is free.
            while (used_slots > 0 && (free_bytes < sz || used_slots >= SLOTS)) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (dir_valid[i] && dir_rank[i] == used_slots - 1) begin
                        dir_valid[i] = 1'b0;
                        free_bytes   = free_bytes + dir_bytes[i];
                        used_slots--;
                        break;
                    end
                end
                evicted++;
            end
            for (int i = 0; i < SLOTS; i++)
                if (dir_valid[i]) dir_rank[i]++;
            for (int i = 0; i < SLOTS; i++) begin
                if (!dir_valid[i]) begin
                    dir_valid[i] = 1'b1;
                    dir_key[i]   = k;
                    dir_bytes[i] = sz;
                    dir_rank[i]  = 0;
                    used_slots++;
                    free_bytes   = free_bytes - sz;
                    break;
                end
            end
            r.status = salcd_pkg::STATUS_INSERTED;
        end
        r.evicted  = (evicted > 127) ? salcd_pkg::EVCNT_MAX
                                     : salcd_pkg::EVCNT_W'(evicted);
        r.free_now = free_bytes;
        return r;
    endfunction

    // Offers one request, in bursts with random gaps, and records its result
    // once the transfer is taken. Called right after a rising edge.
    task automatic send_request(input logic op, input logic [salcd_pkg::KEY_W-1:0] k,
                                input logic [salcd_pkg::BYTES_W-1:0] sz, input bit typed,
                                input t_result typed_res);
        t_result r;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= k;
        i_obj_size <= sz;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        r = predict_response(op, k, sz);
        pending_results.push_back(typed ? typed_res : r);
        sent++;
    endtask

    // The input goes quiet and every result drains before the budget changes.
    task automatic write_budget(input logic [salcd_pkg::BYTES_W-1:0] value);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_budget(value);
    endtask

    function automatic logic [salcd_pkg::BYTES_W-1:0] pick_size(
            input logic [salcd_pkg::BYTES_W-1:0] cap);
        logic [salcd_pkg::BYTES_W-1:0] half;
        half = cap >> 1;
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return $urandom;
            2:       return half;
            3:       return (cap == '1) ? 32'h8000_0000 : half + 1;
            4, 5:    return $urandom_range(0, half);
            default: return $urandom_range(0, (half >> 3) + 1);
        endcase
    endfunction

    function automatic logic [salcd_pkg::BYTES_W-1:0] pick_budget();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return '1;
            4:       return $urandom;
            5:       return 32'd1000;
            default: return $urandom_range(64, 65536);
        endcase
    endfunction

    // Output side: a transfer happens at the next rising edge when valid is
    // high and stall is low; both are stable from the falling edge on.
    always @(negedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                failed = 1'b1;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_status);
                    failed = 1'b1;
                end
                if (o_evicted_count !== exp_res.evicted) begin
                    $error("evicted_count expected %0d actual %0d",
                           exp_res.evicted, o_evicted_count);
                    failed = 1'b1;
                end
                if (o_free_bytes_now !== exp_res.free_now) begin
                    $error("free_bytes_now expected %0h actual %0h",
                           exp_res.free_now, o_free_bytes_now);
                    failed = 1'b1;
                end
            end
        end
    end

    // The receiver stalls on a random pattern whose density is redrawn as the
    // run goes on, and once holds off for a long stretch.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Watchdog: counts cycles in which no transfer of any kind happens.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_row rows[$];

    function automatic t_row item_row(input logic op, input logic [salcd_pkg::KEY_W-1:0] k,
                                      input logic [salcd_pkg::BYTES_W-1:0] sz,
                                      input bit typed, input salcd_pkg::t_status st,
                                      input int ev,
                                      input logic [salcd_pkg::BYTES_W-1:0] fr);
        t_row r;
        r.is_cfg = 1'b0;
        r.op = op;
        r.key = k;
        r.size = sz;
        r.typed = typed;
        r.res.status = st;
        r.res.evicted = salcd_pkg::EVCNT_W'(ev);
        r.res.free_now = fr;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [salcd_pkg::BYTES_W-1:0] value);
        t_row r;
        r = item_row(1'b0, '0, '0, 1'b0, salcd_pkg::STATUS_HIT, 0, '0);
        r.is_cfg = 1'b1;
        r.size = value;
        return r;
    endfunction

    initial begin
        int                             phase;
        int                             n;
        int                             pool;
        logic [salcd_pkg::KEY_W-1:0]    base;
        logic [salcd_pkg::BYTES_W-1:0]  cap;
        logic                           op;
        logic [salcd_pkg::KEY_W-1:0]    k;
        t_result                        none;

        none = '0;
        failed = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        stall_mode = 0;
        cycle_cnt = 0;
        sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = 1'b0;
        i_key = '0;
        i_obj_size = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        apply_budget('0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the budget is zero, so every request answers disabled.
        rows.push_back(item_row(1'b0, 32'h0, 32'h0, 1'b1,
                                salcd_pkg::STATUS_DISABLED, 0, 32'h0));
        rows.push_back(item_row(1'b1, '1, '1, 1'b1,
                                salcd_pkg::STATUS_DISABLED, 0, 32'h0));
        rows.push_back(item_row(1'b1, 32'h5, 32'h0, 1'b1,
                                salcd_pkg::STATUS_DISABLED, 0, 32'h0));
        // Small budget: miss, too large by one byte, exact half, present, hit,
        // a zero-size object, and evictions of one and then two entries.
        rows.push_back(cfg_row(32'd100));
        rows.push_back(item_row(1'b0, 32'd7, 32'd0, 1'b1,
                                salcd_pkg::STATUS_MISS, 0, 32'd100));
        rows.push_back(item_row(1'b1, 32'd7, 32'd51, 1'b1,
                                salcd_pkg::STATUS_TOO_BIG, 0, 32'd100));
        rows.push_back(item_row(1'b1, 32'd7, 32'd50, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'd50));
        rows.push_back(item_row(1'b1, 32'd7, 32'd1, 1'b1,
                                salcd_pkg::STATUS_PRESENT, 0, 32'd50));
        rows.push_back(item_row(1'b0, 32'd7, 32'd9, 1'b1,
                                salcd_pkg::STATUS_HIT, 0, 32'd50));
        rows.push_back(item_row(1'b1, 32'd8, 32'd0, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'd50));
        rows.push_back(item_row(1'b1, 32'd9, 32'd50, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'd0));
        rows.push_back(item_row(1'b1, 32'd10, 32'd50, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 1, 32'd0));
        rows.push_back(item_row(1'b1, '1, '1, 1'b1,
                                salcd_pkg::STATUS_TOO_BIG, 0, 32'd0));
        rows.push_back(item_row(1'b0, '1, '1, 1'b1,
                                salcd_pkg::STATUS_MISS, 0, 32'd0));
        rows.push_back(item_row(1'b1, 32'd11, 32'd50, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 2, 32'd0));
        // Largest budget: the half-size limit must not overflow.
        rows.push_back(cfg_row('1));
        rows.push_back(item_row(1'b1, 32'd0, 32'h7FFF_FFFF, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'h8000_0000));
        rows.push_back(item_row(1'b1, 32'd1, 32'h8000_0000, 1'b1,
                                salcd_pkg::STATUS_TOO_BIG, 0, 32'h8000_0000));
        rows.push_back(item_row(1'b1, 32'd2, 32'h7FFF_FFFF, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'd1));
        rows.push_back(item_row(1'b1, 32'd3, 32'd2, 1'b0,
                                salcd_pkg::STATUS_HIT, 0, 32'd0));
        rows.push_back(item_row(1'b0, 32'd2, 32'd0, 1'b0,
                                salcd_pkg::STATUS_HIT, 0, 32'd0));
        // Budget of one byte: only zero-size objects fit.
        rows.push_back(cfg_row(32'd1));
        rows.push_back(item_row(1'b1, 32'd4, 32'd1, 1'b1,
                                salcd_pkg::STATUS_TOO_BIG, 0, 32'd1));
        rows.push_back(item_row(1'b1, 32'd4, 32'd0, 1'b1,
                                salcd_pkg::STATUS_INSERTED, 0, 32'd1));

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_budget(rows[i].size);
            else
                send_request(rows[i].op, rows[i].key, rows[i].size, rows[i].typed,
                             rows[i].typed ? rows[i].res : none);
        end

        // Random phases, each under its own budget. Keys mostly come from a
        // small pool so that hits, present keys and evictions are frequent.
        phase = 0;
        while (sent < ITEMS) begin
            cap = (phase == 0) ? 32'd1000 : pick_budget();
            write_budget(cap);
            base = $urandom;
            pool = $urandom_range(4, 120);
            n = (cap == 0) ? $urandom_range(10, 30) : $urandom_range(60, 200);
            if (phase == 2) hold_go = 1'b1;
            for (int j = 0; j < n && sent < ITEMS; j++) begin
                if (phase == 4 && j == n / 2) begin
                    i_in_valid <= 1'b0;
                    burst_left = 0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                // Every few phases a run of unique small inserts can fill the
                // slot table so that the full-table eviction is exercised.
                if (phase % 3 == 0 && j < 70) begin
                    op = 1'b1;
                    k = base + j;
                    send_request(op, k, $urandom_range(0, 3), 1'b0, none);
                end else begin
                    op = 1'($urandom_range(0, 1));
                    k = ($urandom_range(0, 15) == 0) ? $urandom
                                                     : base + $urandom_range(0, pool);
                    send_request(op, k, pick_size(cap), 1'b0, none);
                end
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/salcd_pkg.sv
hdl/salcd_mem.sv
hdl/size_aware_lru_cache_directory.sv
dv/tb.sv
